[sv/idf_pkg.sv]
// Shared types and character constants of the integer decimal formatter.
`default_nettype none
package idf_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_BIN,
    CELL_DIG
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     bin_bit;
  } chain_ctrl_t;

endpackage
`default_nettype wire

[sv/idf_digit_cell.sv]
// One BCD digit cell: double-dabble step, digit shift, clear or hold.
`default_nettype none
module idf_digit_cell
  import idf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire cell_op_e op_i,
  input  wire logic     carry_i,
  input  wire logic [3:0] digit_i,
  output logic          carry_o,
  output logic [3:0]    digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:  digit_d = digit_q;
      CELL_CLEAR: digit_d = 4'd0;
      CELL_BIN:   digit_d = {adj[2:0], carry_i};
      CELL_DIG:   digit_d = digit_i;
      default:    digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule
`default_nettype wire

[sv/idf_digit_chain.sv]
// Row of BCD digit cells; binary bits enter at the bottom, digits leave at the top.
`default_nettype none
module idf_digit_chain
  import idf_pkg::*;
#(
  parameter int NDIG = 20
) (
  input  wire logic        clk_i,
  input  wire chain_ctrl_t ctrl_i,
  output logic [3:0]       top_digit_o
);

  logic [3:0] digit [NDIG];
  logic       carry [NDIG];

  for (genvar g = 0; g < NDIG; g++) begin : g_cell
    if (g == 0) begin : g_first
      idf_digit_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.op),
        .carry_i (ctrl_i.bin_bit),
        .digit_i (4'd0),
        .carry_o (carry[g]),
        .digit_o (digit[g])
      );
    end else begin : g_rest
      idf_digit_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (ctrl_i.op),
        .carry_i (carry[g-1]),
        .digit_i (digit[g-1]),
        .carry_o (carry[g]),
        .digit_o (digit[g])
      );
    end
  end

  assign top_digit_o = digit[NDIG-1];

endmodule
`default_nettype wire

[sv/integer_decimal_formatter.sv]
// Integer to decimal ASCII formatter with width, zero padding, alignment and sign options.
//
// One input word carries a value and its format settings; the block answers with the
// characters of the formatted number on the output stream, one character per word,
// with tlast on the final character. Sign prefix, space padding, minus, zero padding,
// digits and trailing padding come out in that order.
// Words are handled one at a time. After acceptance the value is converted by shifting
// it bit by bit through a row of BCD digit cells, then leading zero digits are shifted
// off the top of the row until the leading digit or the last digit is on top, then a
// setup step computes the padding counts. Characters follow at one per cycle while the
// receiver takes them, up to MAX_FIELD+1 characters.
// s_axis_tready_o is high only between items; the next word can be accepted while the
// last character still waits in the output register.
// When the receiver stalls, the output register holds its character and emission pauses.
// Reset empties the output register and returns the block to waiting for input.
`default_nettype none
module integer_decimal_formatter
  import idf_pkg::*;
#(
  parameter int VALUE_BITS = 64,
  parameter int MAX_FIELD  = 40
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // value [63:0], field_width [69:64], min_digits [75:70], unused [79:76]
  input  wire logic [79:0] s_axis_tdata_i,
  // left_justify [0], force_plus [1], space_sign [2], unsigned_mode [3]
  input  wire logic [3:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // char_code [7:0]
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BW   = $clog2(VALUE_BITS);
  localparam int DW   = $clog2(NDIG + 1);
  localparam int CW   = $clog2(MAX_FIELD + 3);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic [DW-1:0]         ndig_q, ndig_d;
  logic [5:0]            field_q, field_d, prec_q, prec_d;
  logic                  left_q, left_d, plus_q, plus_d, pre_q, pre_d, neg_q, neg_d;
  logic [CW-1:0]         pad_q, pad_d, zpad_q, zpad_d, tot_q, tot_d;
  logic                  m_valid_q, m_valid_d;
  logic [7:0]            m_data_q, m_data_d;
  logic                  m_last_q, m_last_d;

  chain_ctrl_t           chain_ctrl;
  logic [3:0]            top_digit;

  logic [VALUE_BITS-1:0] in_val;
  logic                  in_neg, in_uns, accept, out_free;
  logic [5:0]            wid6, prec6;
  logic [CW-1:0]         wid, prec, ndig_c, ndt, body;

  assign in_val   = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_uns   = s_axis_tuser_i[3];
  assign in_neg   = !in_uns && in_val[VALUE_BITS-1];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign wid6   = (field_q > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : field_q;
  assign prec6  = (prec_q > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : prec_q;
  assign wid    = CW'(wid6);
  assign prec   = CW'(prec6);
  assign ndig_c = CW'(ndig_q);
  assign ndt    = (prec > ndig_c) ? prec : ndig_c;
  assign body   = ndt + CW'(neg_q);

  always_comb begin
    state_d         = state_q;
    mag_d           = mag_q;
    bit_d           = bit_q;
    ndig_d          = ndig_q;
    field_d         = field_q;
    prec_d          = prec_q;
    left_d          = left_q;
    plus_d          = plus_q;
    pre_d           = pre_q;
    neg_d           = neg_q;
    pad_d           = pad_q;
    zpad_d          = zpad_q;
    tot_d           = tot_q;
    m_valid_d       = m_valid_q && !m_axis_tready_i;
    m_data_d        = m_data_q;
    m_last_d        = m_last_q;
    chain_ctrl.op      = CELL_HOLD;
    chain_ctrl.bin_bit = mag_q[VALUE_BITS-1];

    unique case (state_q)
      ST_IDLE: begin
        chain_ctrl.op = CELL_CLEAR;
        if (accept) begin
          mag_d   = in_neg ? (~in_val + 1'b1) : in_val;
          field_d = s_axis_tdata_i[69:64];
          prec_d  = s_axis_tdata_i[75:70];
          left_d  = s_axis_tuser_i[0];
          plus_d  = s_axis_tuser_i[1];
          pre_d   = !in_uns && !in_neg && (s_axis_tuser_i[1] || s_axis_tuser_i[2]);
          neg_d   = in_neg;
          bit_d   = BW'(VALUE_BITS - 1);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        chain_ctrl.op = CELL_BIN;
        mag_d         = mag_q << 1;
        bit_d         = bit_q - 1'b1;
        if (bit_q == '0) begin
          ndig_d  = DW'(NDIG);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (top_digit == 4'd0 && ndig_q > DW'(1)) begin
          chain_ctrl.op = CELL_DIG;
          ndig_d        = ndig_q - 1'b1;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        zpad_d  = (prec > ndig_c) ? prec - ndig_c : '0;
        pad_d   = (wid > body) ? wid - body : '0;
        tot_d   = CW'(pre_q) + ((wid > body) ? wid : body);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_last_d  = (tot_q == CW'(1));
          tot_d     = tot_q - 1'b1;
          priority if (pre_q) begin
            m_data_d = plus_q ? CHAR_PLUS : CHAR_SPACE;
            pre_d    = 1'b0;
          end else if (!left_q && pad_q != '0) begin
            m_data_d = CHAR_SPACE;
            pad_d    = pad_q - 1'b1;
          end else if (neg_q) begin
            m_data_d = CHAR_MINUS;
            neg_d    = 1'b0;
          end else if (zpad_q != '0) begin
            m_data_d = CHAR_ZERO;
            zpad_d   = zpad_q - 1'b1;
          end else if (ndig_q != '0) begin
            m_data_d      = CHAR_ZERO | {4'd0, top_digit};
            ndig_d        = ndig_q - 1'b1;
            chain_ctrl.op = CELL_DIG;
          end else begin
            m_data_d = CHAR_SPACE;
            pad_d    = pad_q - 1'b1;
          end
          if (tot_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      bit_q     <= '0;
      ndig_q    <= '0;
      pre_q     <= 1'b0;
      neg_q     <= 1'b0;
      pad_q     <= '0;
      zpad_q    <= '0;
      tot_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      bit_q     <= bit_d;
      ndig_q    <= ndig_d;
      pre_q     <= pre_d;
      neg_q     <= neg_d;
      pad_q     <= pad_d;
      zpad_q    <= zpad_d;
      tot_q     <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    field_q  <= field_d;
    prec_q   <= prec_d;
    left_q   <= left_d;
    plus_q   <= plus_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  idf_digit_chain #(
    .NDIG (NDIG)
  ) u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (chain_ctrl),
    .top_digit_o (top_digit)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // Emission always has at least one character left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> tot_q != '0)
    else $error("emission state with no characters left");

  // The digit count never falls below one while leading zeros are dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NORM |-> ndig_q != '0)
    else $error("digit count reached zero during normalization");

  // The final character of a number carries tlast, and the block then returns to waiting for input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && tot_q == CW'(1)) |=>
      (m_axis_tvalid_o && m_axis_tlast_o && state_q == ST_IDLE))
    else $error("last character not flagged at end of number");

endmodule
`default_nettype wire

[test/integer_decimal_formatter_tb.sv]
// Self-checking testbench that streams integers and format settings and checks every character.
`default_nettype none
module integer_decimal_formatter_tb
  import idf_pkg::*;
();

  localparam int FIELD_LIMIT = 40;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LEFT_BIT  = 0;
  localparam int PLUS_BIT  = 1;
  localparam int SPACE_BIT = 2;
  localparam int UNS_BIT   = 3;

  class digit_string_board;
    typedef struct packed {
      logic [7:0] code;
      logic       last;
    } char_word_t;

    char_word_t expected_chars[$];
    int         errors;

    function void push_char(logic [7:0] c);
      expected_chars.push_back('{code: c, last: 1'b0});
    endfunction

    function void note_number(logic [63:0] v, logic [5:0] fw, logic [5:0] md, logic [3:0] fl);
      logic [63:0] mag;
      logic [3:0]  digs [0:19];
      bit          neg;
      int          width, prec, ndig, total, body, pad;
      mag   = v;
      neg   = 1'b0;
      ndig  = 0;
      width = (fw > FIELD_LIMIT) ? FIELD_LIMIT : int'(fw);
      prec  = (md > FIELD_LIMIT) ? FIELD_LIMIT : int'(md);
      if (!fl[UNS_BIT] && v[63]) begin
        neg = 1'b1;
        mag = -v;
      end
      do begin
        digs[ndig] = 4'(mag % 64'd10);
        mag = mag / 64'd10;
        ndig++;
      end while (mag != 0);
      total = (ndig > prec) ? ndig : prec;
      body  = total + int'(neg);
      pad   = (width > body) ? width - body : 0;
      if (!fl[UNS_BIT] && !neg) begin
        if (fl[PLUS_BIT]) begin
          push_char(CHAR_PLUS);
        end else if (fl[SPACE_BIT]) begin
          push_char(CHAR_SPACE);
        end
      end
      if (!fl[LEFT_BIT]) begin
        repeat (pad) push_char(CHAR_SPACE);
      end
      if (neg) begin
        push_char(CHAR_MINUS);
      end
      repeat (total - ndig) push_char(CHAR_ZERO);
      for (int i = ndig - 1; i >= 0; i--) begin
        push_char(CHAR_ZERO + digs[i]);
      end
      if (fl[LEFT_BIT]) begin
        repeat (pad) push_char(CHAR_SPACE);
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    function void check_char(logic [7:0] code, logic last);
      char_word_t want;
      if (expected_chars.size() == 0) begin
        if (errors < 10) begin
          $display("ERROR: unexpected character %h last %b", code, last);
        end
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (code !== want.code || last !== want.last) begin
          if (errors < 10) begin
            $display("ERROR: character %h last %b, expected %h last %b",
                     code, last, want.code, want.last);
          end
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire logic   s_axis_tready_o;
  wire logic   m_axis_tvalid_o;
  wire logic [7:0] m_axis_tdata_o;
  wire logic   m_axis_tlast_o;

  int tx_idle_pct = 15;
  int rx_idle_pct = 60;
  int cycles = 0;
  digit_string_board board;

  integer_decimal_formatter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_axis_tready_o) begin
      board.note_number(s_tdata[63:0], s_tdata[69:64], s_tdata[75:70], s_tuser);
    end
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      board.check_char(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL integer_decimal_formatter");
      $finish;
    end
  end

  task automatic send_item(input logic [63:0] v, input int fw, input int md,
                           input bit la, input bit fp, input bit ss, input bit um);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, 6'(md), 6'(fw), v};
    s_tuser  <= {um, ss, fp, la};
    do @(posedge clk); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic send_random(input int count);
    logic [63:0] v;
    logic [63:0] p;
    logic [3:0]  fl;
    int          fw, md;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(5))
        0: v = {$urandom, $urandom};
        1: v = 64'($urandom_range(99999));
        2: v = -64'($urandom_range(99999));
        3: begin
          p = 64'd1;
          repeat ($urandom_range(19)) p = p * 64'd10;
          v = p + 64'($urandom_range(2)) - 64'd1;
          if ($urandom_range(1)) begin
            v = -v;
          end
        end
        4: begin
          case ($urandom_range(5))
            0: v = 64'd0;
            1: v = 64'd1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h7FFF_FFFF_FFFF_FFFF;
            4: v = 64'hFFFF_FFFF_FFFF_FFFF;
            default: v = 64'h8000_0000_0000_0001;
          endcase
        end
        default: v = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      case ($urandom_range(9))
        7, 8: fw = $urandom_range(45, 25);
        9: fw = $urandom_range(63);
        default: fw = $urandom_range(24);
      endcase
      case ($urandom_range(9))
        7, 8: md = $urandom_range(45, 20);
        9: md = $urandom_range(63);
        default: md = $urandom_range(22);
      endcase
      fl = 4'($urandom_range(15));
      send_item(v, fw, md, fl[LEFT_BIT], fl[PLUS_BIT], fl[SPACE_BIT], fl[UNS_BIT]);
      if (n % 50 == 49) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(64'd0, 0, 0, 0, 0, 0, 0);
    send_item(64'd0, 5, 0, 1, 1, 0, 0);
    send_item(64'h8000_0000_0000_0000, 0, 0, 0, 1, 1, 0);
    send_item(64'h8000_0000_0000_0000, 25, 0, 0, 0, 0, 1);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 1, 1, 1);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 1, 0, 0);
    send_item(64'd42, 6, 0, 0, 0, 1, 0);
    send_item(64'd42, 6, 0, 1, 1, 1, 0);
    send_item(-64'd42, 8, 0, 0, 1, 1, 0);
    send_item(-64'd42, 8, 0, 1, 0, 0, 0);
    send_item(64'd12345, 40, 0, 1, 0, 0, 0);
    send_item(64'd12345, 63, 63, 0, 1, 0, 0);
    send_item(-64'd7, 63, 63, 1, 0, 0, 0);
    send_item(64'd12345, 12, 8, 0, 0, 0, 0);
    send_item(-64'd12345, 4, 9, 0, 0, 0, 0);
    send_item(64'd0, 3, 40, 0, 0, 1, 0);
    send_item(64'd9, 41, 41, 1, 1, 1, 1);
    wait_drained();

    send_random(150);
    wait_drained();
    tx_idle_pct = 60;
    rx_idle_pct = 15;
    send_random(150);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(152);

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS integer_decimal_formatter");
    end else begin
      $display("FAIL integer_decimal_formatter");
    end
    $finish;
  end

endmodule
`default_nettype wire
